[sv/arenv_pkg.sv]
// shared constants for the attack/release envelope
`default_nettype none
package arenv_pkg;
	localparam int TIME_BITS_DEF       = 32;
	localparam int LEVEL_FRAC_BITS_DEF = 16;

	// ramp durations in ms
	localparam int DUR_W = 15;
	localparam logic [DUR_W-1:0] DEFAULT_ATTACK  = 15'd10;
	localparam logic [DUR_W-1:0] DEFAULT_RELEASE = 15'd500;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;

	// phase codes as seen on the result
	localparam logic [1:0] PH_QUIET   = 2'd0;
	localparam logic [1:0] PH_ATTACK  = 2'd1;
	localparam logic [1:0] PH_RELEASE = 2'd2;

	localparam logic FUNC_TICK    = 1'b0;
	localparam logic FUNC_TRIGGER = 1'b1;
endpackage
`default_nettype wire

[sv/attack_release_envelope.sv]
// top level: envelope state, sequencer and result register
`default_nettype none
// Linear attack/release envelope. Each transaction on the input channel is a
// tick (func 0) or a trigger (func 1) stamped with the current ms time, and
// yields exactly one result transaction with the new level (full scale is
// 1 << LEVEL_FRAC_BITS) and phase. A tick inside a ramp runs one multiply
// and then a shared restoring divider that retires one quotient bit per
// cycle, and only then loads the result register; triggers, quiet ticks
// and ramp ends skip the multiply and the divider and load it directly.
// One transaction is processed at a time; in_ready is high only
// while the sequencer is idle. Register writes made outside quiet take effect
// at the next return to quiet.
module attack_release_envelope import arenv_pkg::*; #(
	parameter int TIME_BITS       = TIME_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_IDX_W-1:0]       cfg_idx,
	input  wire logic [DUR_W-1:0]           cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       func,
	input  wire logic [TIME_BITS-1:0]       now_ms,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [LEVEL_FRAC_BITS:0]   level,
	output logic      [1:0]                 phase
);
	localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
	localparam int PROD_W  = LEVEL_W + DUR_W;
	localparam logic [LEVEL_W-1:0] FULL = LEVEL_W'(1) << LEVEL_FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MUL  = 4'b0010,
		S_DIV  = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [DUR_W-1:0]    attack_ms_q, release_ms_q;
	logic [DUR_W-1:0]    act_attack_q, act_release_q;
	logic [1:0]          cur_phase_q;
	logic [LEVEL_W-1:0]  cur_level_q;
	logic [LEVEL_W-1:0]  start_level_q;
	logic [TIME_BITS-1:0] start_time_q;
	logic [DUR_W-1:0]    duration_q;
	logic [LEVEL_W-1:0]  op_a_q;
	logic [DUR_W-1:0]    op_b_q;
	logic [DUR_W-1:0]    dvs_q;
	logic                out_valid_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [1:0]          phase_q;

	logic                in_fire;
	logic [TIME_BITS-1:0] elapsed;
	logic [DUR_W-1:0]    dur_eff;
	logic                ramp_over;
	logic [DUR_W-1:0]    new_attack, new_release;
	logic [DUR_W-1:0]    pick_attack, pick_release;
	logic [PROD_W-1:0]   product;
	logic                div_done, div_rem_nz;
	logic [PROD_W-1:0]   div_quo;
	logic [LEVEL_W-1:0]  quo;
	logic [LEVEL_W-1:0]  drop;
	logic                out_load;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		elapsed   = now_ms - start_time_q;
		dur_eff   = (duration_q != '0) ? duration_q : DUR_W'(1);
		ramp_over = (elapsed > TIME_BITS'(dur_eff));
		product   = PROD_W'(op_a_q) * PROD_W'(op_b_q);
		quo       = div_quo[LEVEL_W-1:0];
		drop      = quo + LEVEL_W'(div_rem_nz);
		out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	// register values after a write this cycle, zero picks the default
	always_comb begin
		new_attack  = attack_ms_q;
		new_release = release_ms_q;
		if (cfg_we) begin
			unique case (cfg_idx)
				REG_ATTACK:  new_attack  = cfg_data;
				REG_RELEASE: new_release = cfg_data;
				default: ;
			endcase
		end
		pick_attack  = (new_attack != '0) ? new_attack : DEFAULT_ATTACK;
		pick_release = (new_release != '0) ? new_release : DEFAULT_RELEASE;
	end

	arenv_div #(
		.DVD_W(PROD_W),
		.DVS_W(DUR_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_MUL),
		.dividend(product),
		.divisor (dvs_q),
		.done    (div_done),
		.quotient(div_quo),
		.rem_nz  (div_rem_nz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			attack_ms_q   <= DEFAULT_ATTACK;
			release_ms_q  <= DEFAULT_RELEASE;
			act_attack_q  <= DEFAULT_ATTACK;
			act_release_q <= DEFAULT_RELEASE;
			cur_phase_q   <= PH_QUIET;
			cur_level_q   <= '0;
			start_level_q <= '0;
			start_time_q  <= '0;
			duration_q    <= DEFAULT_ATTACK;
			out_valid_q   <= 1'b0;
		end else begin
			attack_ms_q  <= new_attack;
			release_ms_q <= new_release;
			if (cfg_we && cur_phase_q == PH_QUIET) begin
				act_attack_q  <= pick_attack;
				act_release_q <= pick_release;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_OUT;
						if (func == FUNC_TRIGGER) begin
							if (cur_level_q != FULL) begin
								start_level_q <= cur_level_q;
								start_time_q  <= now_ms;
								duration_q    <= act_attack_q;
								cur_phase_q   <= PH_ATTACK;
							end
						end else if (cur_phase_q == PH_ATTACK) begin
							if (ramp_over) begin
								cur_level_q   <= FULL;
								start_level_q <= FULL;
								start_time_q  <= now_ms;
								duration_q    <= act_release_q;
								cur_phase_q   <= PH_RELEASE;
							end else begin
								state_q <= S_MUL;
							end
						end else if (cur_phase_q == PH_RELEASE) begin
							if (ramp_over) begin
								cur_level_q   <= '0;
								start_level_q <= '0;
								cur_phase_q   <= PH_QUIET;
								act_attack_q  <= pick_attack;
								act_release_q <= pick_release;
							end else begin
								state_q <= S_MUL;
							end
						end
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_OUT;
						if (cur_phase_q == PH_ATTACK) begin
							cur_level_q <= start_level_q + quo;
						end else begin
							// release level is the exact value truncated, so round the drop up
							cur_level_q <= (drop < start_level_q) ? start_level_q - drop : '0;
						end
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// multiply operands: span toward full in attack, start level in release
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_a_q <= (cur_phase_q == PH_ATTACK)
				? ((start_level_q < FULL) ? FULL - start_level_q : '0)
				: start_level_q;
			op_b_q <= elapsed[DUR_W-1:0];
			dvs_q  <= dur_eff;
		end
		if (out_load) begin
			level_q <= cur_level_q;
			phase_q <= cur_phase_q;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign phase     = phase_q;
endmodule
`default_nettype wire

[sv/arenv_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none
module arenv_div import arenv_pkg::*; #(
	parameter int DVD_W = 32,
	parameter int DVS_W = 15
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic      [DVD_W-1:0] quotient,
	output logic                  rem_nz
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient bits shift in at the bottom as the dividend shifts out the top
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
	assign rem_nz   = |rem_q;
endmodule
`default_nettype wire
